// ----- hw/rtl/frequency_ranked_unary_coder_top_defines.svh -----
// Assertion macros shared by the coder RTL.
`ifndef FREQUENCY_RANKED_UNARY_CODER_TOP_DEFINES_SVH
`define FREQUENCY_RANKED_UNARY_CODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define FRC_ASSERT_IMPLIES(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define FRC_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed");

`else

`define FRC_ASSERT_IMPLIES(label, clk, rstn, a, b)
`define FRC_ASSERT_NEXT(label, clk, rstn, a, b)

`endif

`endif

// ----- hw/rtl/frc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

    // Action codes of an input beat.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;          // an input beat is taken this cycle
        logic start_sweep;     // latch the queried count, reset sweep index
        logic step;            // read the next table entry
        logic out_load;        // move the finished result into the output register
    } frc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;             // queried symbol is in the alphabet and loaded
        logic sweep_last;      // sweep index is at the last table entry
    } frc_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/frequency_ranked_unary_coder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                                   Direction  Beat
// s_       s_valid s_ready s_action s_symbol s_count  in      clear, load or query
// m_       m_valid m_ready m_rank m_code_length m_present out  one result per query
//
// Clear and load beats are taken while idle and yield no result.
// A query goes idle, check, sweep, drain, done (an absent symbol skips sweep and drain);
// the sweep reads one count table entry per cycle from one RAM port.
// Reset (aresetn low, synchronous) empties the table at once; no clearing pass.
// A waiting result does not block clear or load beats; a query finishing while the
// output is still held waits for m_ready.

module frequency_ranked_unary_coder_top #(
    parameter int NUM_SYMBOLS = 256,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_symbol,
    input  wire logic [31:0] s_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_rank,
    output logic      [8:0]  m_code_length,
    output logic             m_present
);

    frc_pkg::frc_cmd_t    cmd;
    frc_pkg::frc_status_t status;

    frc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    frc_datapath #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_action      (s_action),
        .s_symbol      (s_symbol),
        .s_count       (s_count),
        .m_rank        (m_rank),
        .m_code_length (m_code_length),
        .m_present     (m_present)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/frc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/frc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frc_datapath #(
    parameter int NUM_SYMBOLS = 256,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire frc_pkg::frc_cmd_t cmd,
    output frc_pkg::frc_status_t   status,
    input  wire logic [1:0]        s_action,
    input  wire logic [7:0]        s_symbol,
    input  wire logic [31:0]       s_count,
    output logic      [7:0]        m_rank,
    output logic      [8:0]        m_code_length,
    output logic                   m_present
);

    localparam int SYM_W = $clog2(NUM_SYMBOLS);

    logic [NUM_SYMBOLS-1:0] loaded_reg;
    logic [SYM_W-1:0]       sym_reg;
    logic                   hit_reg;
    logic [COUNT_BITS-1:0]  self_cnt_reg;
    logic [SYM_W-1:0]       idx_reg;
    logic                   cmp_valid_reg;
    logic [SYM_W-1:0]       cmp_idx_reg;
    logic [SYM_W-1:0]       rank_reg;
    logic [7:0]             m_rank_reg;
    logic [8:0]             m_code_length_reg;
    logic                   m_present_reg;

    logic                   in_range;
    logic [SYM_W-1:0]       in_sym;
    logic [COUNT_BITS-1:0]  wdata;
    logic                   ram_we;
    logic [SYM_W-1:0]       raddr;
    logic [COUNT_BITS-1:0]  rdata;
    logic                   ranks_ahead;

    // Symbols at or above the alphabet size are ignored by loads and miss on queries.
    assign in_range = ({1'b0, s_symbol} < 9'(NUM_SYMBOLS));
    assign in_sym   = s_symbol[SYM_W-1:0];

    // Keep the count in its low COUNT_BITS bits.
    generate
        if (COUNT_BITS > 32) begin : g_wide
            assign wdata = {{(COUNT_BITS-32){1'b0}}, s_count};
        end else begin : g_narrow
            assign wdata = s_count[COUNT_BITS-1:0];
        end
    endgenerate

    assign ram_we = cmd.accept && (s_action == frc_pkg::ACT_LOAD) && in_range;

    // While an input beat is accepted the read port looks up its symbol, otherwise it follows the sweep.
    assign raddr = cmd.accept ? in_sym : idx_reg;

    frc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_SYMBOLS)
    ) u_counts (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_sym),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Entry under compare ranks ahead: higher count, or equal count and higher symbol.
    always_comb begin
        ranks_ahead = 1'b0;
        if (loaded_reg[cmp_idx_reg] && (cmp_idx_reg != sym_reg)) begin
            if (rdata != self_cnt_reg) begin
                ranks_ahead = (rdata > self_cnt_reg);
            end else begin
                ranks_ahead = (cmp_idx_reg > sym_reg);
            end
        end
    end

    // Loaded bits: cleared at once by reset or a clear beat, set by a load beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
        end else if (cmd.accept && (s_action == frc_pkg::ACT_CLEAR)) begin
            loaded_reg <= '0;
        end else if (ram_we) begin
            loaded_reg[in_sym] <= 1'b1;
        end
    end

    // Compare pipeline valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= cmd.step;
        end
    end

    // Query registers, sweep index and rank accumulator.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sym_reg  <= in_sym;
            hit_reg  <= in_range && loaded_reg[in_sym];
            rank_reg <= '0;
        end
        if (cmd.start_sweep) begin
            self_cnt_reg <= rdata;
            idx_reg      <= '0;
        end
        if (cmd.step) begin
            idx_reg     <= idx_reg + 1'b1;
            cmp_idx_reg <= idx_reg;
        end
        if (cmp_valid_reg && ranks_ahead) begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_present_reg <= hit_reg;
            if (hit_reg) begin
                m_rank_reg        <= 8'(rank_reg);
                m_code_length_reg <= 9'(rank_reg) + 9'd1;
            end else begin
                m_rank_reg        <= '0;
                m_code_length_reg <= '0;
            end
        end
    end

    assign status.hit        = hit_reg;
    assign status.sweep_last = (idx_reg == SYM_W'(NUM_SYMBOLS - 1));

    assign m_rank        = m_rank_reg;
    assign m_code_length = m_code_length_reg;
    assign m_present     = m_present_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/frc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "frequency_ranked_unary_coder_top_defines.svh"

module frc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_action,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output frc_pkg::frc_cmd_t         cmd,
    input  wire frc_pkg::frc_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;

    // Commands decoded from the current state.
    always_comb begin
        cmd             = '0;
        cmd.accept      = (state_reg == ST_IDLE) && s_valid;
        cmd.start_sweep = (state_reg == ST_CHECK) && status.hit;
        cmd.step        = (state_reg == ST_SWEEP);
        cmd.out_load    = (state_reg == ST_DONE) && out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    // State and output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && (s_action == frc_pkg::ACT_QUERY)) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    state_reg <= status.hit ? ST_SWEEP : ST_DONE;
                end
                ST_SWEEP: begin
                    if (status.sweep_last) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A result never overwrites one that is still waiting.
    `FRC_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, cmd.out_load, !out_valid_reg || m_ready)
    // The last compare drains before the result is loaded.
    `FRC_ASSERT_NEXT(a_drain_done, aclk, aresetn, state_reg == ST_DRAIN, state_reg == ST_DONE)
    // The sweep never runs while input beats are taken.
    `FRC_ASSERT_IMPLIES(a_ready_no_step, aclk, aresetn, s_ready, !cmd.step)

endmodule

`default_nettype wire
